@@ sv/stdf_pkg.sv @@
package stdf_pkg;

    localparam logic [7:0] STX_BYTE    = 8'h02;
    localparam logic [7:0] ETX_BYTE    = 8'h03;
    localparam logic [7:0] ESC_BYTE    = 8'h10;
    localparam logic [7:0] ESC_STX     = 8'h82;
    localparam logic [7:0] ESC_ETX     = 8'h83;
    localparam logic [7:0] ESC_ESC     = 8'h90;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_DATA = 3'd3,
        PH_ESC  = 3'd4,
        PH_BCC  = 3'd5,
        PH_ETX  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_START   = 2'd1,
        ERR_ESCAPE  = 2'd2,
        ERR_END     = 2'd3
    } t_err;

    typedef struct packed {
        logic       ack;
        logic [3:0] len;
        logic [4:0] addr;
        logic [3:0] idx;
        logic [7:0] data;
        t_err       err;
        t_kind      kind;
        logic       last;
    } t_result;

endpackage

@@ sv/stdf_in_reg.sv @@
module stdf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import stdf_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ sv/stdf_core.sv @@
module stdf_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output stdf_pkg::t_result o_res
);
    import stdf_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_start_ok, n_start_ok;
    logic [2:0] r_hdr1, n_hdr1;
    logic [4:0] r_addr, n_addr;
    logic [3:0] r_len, n_len;
    logic       r_ack, n_ack;
    logic [3:0] r_count, n_count;

    logic [3:0] count_inc;
    logic       data_end;
    logic       esc_ok;
    logic [7:0] esc_val;

    assign count_inc = r_count + 4'd1;
    assign data_end  = (count_inc == 4'd0) || (count_inc >= r_len);

    always_comb begin
        esc_ok  = 1'b1;
        esc_val = ESC_BYTE;
        unique case (i_byte)
            ESC_STX: esc_val = STX_BYTE;
            ESC_ETX: esc_val = ETX_BYTE;
            ESC_ESC: esc_val = ESC_BYTE;
            default: esc_ok  = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_start_ok = r_start_ok;
        n_hdr1     = r_hdr1;
        n_addr     = r_addr;
        n_len      = r_len;
        n_ack      = r_ack;
        n_count    = r_count;
        unique case (r_phase)
            PH_HDR1: begin
                n_hdr1  = {i_byte[3], i_byte[1:0]};
                n_phase = PH_HDR2;
            end
            PH_HDR2: begin
                n_phase = PH_HDR0;
                if (r_start_ok) begin
                    n_addr  = {r_hdr1[1:0], i_byte[7:5]};
                    n_len   = i_byte[3:0];
                    n_ack   = r_hdr1[2];
                    n_count = 4'd0;
                    n_phase = (i_byte[3:0] == 4'd0) ? PH_BCC : PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_byte == ESC_BYTE) begin
                    n_phase = PH_ESC;
                end else begin
                    n_count = count_inc;
                    n_phase = data_end ? PH_BCC : PH_DATA;
                end
            end
            PH_ESC: begin
                if (esc_ok) begin
                    n_count = count_inc;
                    n_phase = data_end ? PH_BCC : PH_DATA;
                end else begin
                    n_phase = PH_HDR0;
                end
            end
            PH_BCC: n_phase = PH_ETX;
            PH_ETX: n_phase = PH_HDR0;
            default: begin
                n_start_ok = (i_byte == STX_BYTE);
                n_phase    = PH_HDR1;
            end
        endcase
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res.kind  = KIND_DATA;
        o_res.err   = ERR_NONE;
        o_res.data  = 8'd0;
        o_res.idx   = 4'd0;
        o_res.addr  = r_addr;
        o_res.len   = r_len;
        o_res.ack   = r_ack;
        o_res.last  = 1'b0;
        unique case (r_phase)
            PH_HDR2: begin
                if (!r_start_ok) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_REJECT;
                    o_res.err   = ERR_START;
                    o_res.addr  = 5'd0;
                    o_res.len   = 4'd0;
                    o_res.ack   = 1'b0;
                    o_res.last  = 1'b1;
                end
            end
            PH_DATA: begin
                if (i_byte != ESC_BYTE) begin
                    o_res_valid = 1'b1;
                    o_res.data  = i_byte;
                    o_res.idx   = r_count;
                end
            end
            PH_ESC: begin
                o_res_valid = 1'b1;
                if (esc_ok) begin
                    o_res.data = esc_val;
                    o_res.idx  = r_count;
                end else begin
                    o_res.kind = KIND_REJECT;
                    o_res.err  = ERR_ESCAPE;
                    o_res.last = 1'b1;
                end
            end
            PH_ETX: begin
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                if (i_byte == ETX_BYTE) begin
                    o_res.kind = KIND_DONE;
                end else begin
                    o_res.kind = KIND_REJECT;
                    o_res.err  = ERR_END;
                end
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_start_ok <= 1'b0;
            r_hdr1     <= 3'd0;
            r_addr     <= 5'd0;
            r_len      <= 4'd0;
            r_ack      <= 1'b0;
            r_count    <= 4'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_start_ok <= n_start_ok;
            r_hdr1     <= n_hdr1;
            r_addr     <= n_addr;
            r_len      <= n_len;
            r_ack      <= n_ack;
            r_count    <= n_count;
        end
    end

endmodule

@@ sv/stdf_out_reg.sv @@
module stdf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  stdf_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output stdf_pkg::t_result o_res
);
    import stdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ sv/stuffed_telegram_deframer.sv @@
// Byte-stuffed telegram deframer.
// Slave channel: one raw serial byte per transfer on i_s_tdata.
// Master channel: one result per transfer. o_m_tuser carries the kind
// (data byte, frame complete, frame rejected); o_m_tlast marks the final
// result of a frame. o_m_tdata carries error code, unstuffed byte, byte
// index, module address, announced length and the ack flag.
// Header, check and escape bytes produce no transfer; the end byte does, and a
// wrong start byte yields a reject when the third header byte is decoded.
// A byte taken sits in the input register, is decoded against the frame state
// and its result is loaded into the output register, which offers it.
// Throughput: one byte per cycle while the output register can take a result,
// set by the single decode stage between the input and output registers.
// Stall: while a result waits in the output register and i_m_tready is low,
// the decode stage holds every byte, also those that yield no result; the
// input register then fills and o_s_tready drops.
// Reset (i_rst_n low, synchronous): both registers empty, the deframer
// waits for the first header byte.
module stuffed_telegram_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [stdf_pkg::IN_DATA_W-1:0]    i_s_tdata,  // rx_byte[7:0]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // error_code[1:0], data_byte[9:2], byte_index[13:10], module_addr[18:14],
    // frame_length[22:19], is_ack[23]
    output logic [stdf_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic [stdf_pkg::OUT_USER_W-1:0]   o_m_tuser,  // out_kind[1:0]
    output logic                              o_m_tlast
);
    import stdf_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign step = in_valid && out_free;

    stdf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_advance (step),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    stdf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    stdf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.ack, out_res.len, out_res.addr, out_res.idx,
                        out_res.data, out_res.err};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

endmodule
